@@ rtl/drive_mode_supervisor_top_macros.svh @@
// ----------------------------------------------------------------------------
// Drive mode supervisor assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DRIVE_MODE_SUPERVISOR_TOP_MACROS_SVH
`define DRIVE_MODE_SUPERVISOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("drive mode supervisor check failed");

// The consequent must hold in the cycle after the antecedent.
`define DMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("drive mode supervisor check failed");

`endif

@@ rtl/dms_pkg.sv @@
// ----------------------------------------------------------------------------
// Drive mode supervisor package
// Shared codes for stop commands, source selection and controller requests.
// ----------------------------------------------------------------------------
package dms_pkg;

  // Width of a configuration register index and of its write data.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ModeW    = 3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_CRUISE_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PLANNER_LIMIT = 2'd1;

  // Emergency stop codes, both on the command input and toward the base.
  typedef enum logic [1:0] {
    STOP_NONE  = 2'd0,
    STOP_SET   = 2'd1,
    STOP_RESET = 2'd2
  } stop_e;

  // Requested drive source.
  typedef enum logic [1:0] {
    SEL_JOY     = 2'd0,
    SEL_CRUISE  = 2'd1,
    SEL_PLANNER = 2'd2
  } sel_e;

  // Requests sent to the cruise controller and the path planner.
  typedef enum logic [1:0] {
    REQ_NONE      = 2'd0,
    REQ_ENGAGE    = 2'd1,
    REQ_DISENGAGE = 2'd2
  } req_e;

  // Decision for one item, handed from the mode machine to the output stage.
  typedef struct packed {
    sel_e             src;
    req_e             cruise_req;
    req_e             planner_req;
    stop_e            base_stop;
    logic [ModeW-1:0] mode;
  } dms_decision_t;

endpackage

@@ rtl/dms_mode_fsm.sv @@
// ----------------------------------------------------------------------------
// Drive mode state machine
// Holds the drive mode and the engage wait counters and decides, for each
// item, the source to drive, the controller requests and the base stop code.
// ----------------------------------------------------------------------------
module dms_mode_fsm import dms_pkg::*; #(
  parameter int unsigned WAIT_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [1:0]          estop_cmd_i,
  input  logic [1:0]          source_select_i,
  input  logic [2:0]          cruise_status_i,
  input  logic [2:0]          planner_status_i,
  input  logic [CfgDataW-1:0] cruise_limit_i,
  input  logic [CfgDataW-1:0] planner_limit_i,
  output dms_decision_t       decision_o
);

  typedef enum logic [ModeW-1:0] {
    MODE_JOY        = 3'd0,
    MODE_TO_CRUISE  = 3'd1,
    MODE_CRUISE     = 3'd2,
    MODE_TO_PLANNER = 3'd3,
    MODE_PLANNER    = 3'd4,
    MODE_STOP       = 3'd5
  } mode_e;

  // Controller status codes that matter while engaging.
  localparam logic [2:0] CS_OFF         = 3'd0;
  localparam logic [2:0] CS_ENGAGED_G   = 3'd3;
  localparam logic [2:0] CS_ENGAGED_U   = 3'd4;
  localparam logic [2:0] CS_FAILURE     = 3'd5;
  localparam logic [2:0] PS_OFF         = 3'd0;
  localparam logic [2:0] PS_ENGAGED     = 3'd3;
  localparam logic [2:0] PS_FAILURE     = 3'd4;

  localparam int unsigned LimW = (WAIT_BITS > CfgDataW) ? WAIT_BITS : CfgDataW;
  localparam logic [LimW-1:0] WaitMaxExt = LimW'({WAIT_BITS{1'b1}});

  mode_e                mode_q, mode_d;
  logic [WAIT_BITS-1:0] cruise_wait_q, cruise_wait_d;
  logic [WAIT_BITS-1:0] planner_wait_q, planner_wait_d;
  logic [LimW-1:0]      cruise_lim_ext, planner_lim_ext;
  logic [LimW-1:0]      cruise_lim_sat, planner_lim_sat;
  logic [WAIT_BITS-1:0] cruise_lim, planner_lim;
  stop_e                stop_cmd;

  // Wait limits saturate at the largest count the counters can hold.
  always_comb begin
    cruise_lim_ext  = LimW'(cruise_limit_i);
    planner_lim_ext = LimW'(planner_limit_i);
    cruise_lim_sat  = (cruise_lim_ext > WaitMaxExt) ? WaitMaxExt : cruise_lim_ext;
    planner_lim_sat = (planner_lim_ext > WaitMaxExt) ? WaitMaxExt : planner_lim_ext;
    cruise_lim      = cruise_lim_sat[WAIT_BITS-1:0];
    planner_lim     = planner_lim_sat[WAIT_BITS-1:0];
  end

  // Stop command code three carries no meaning and acts as no command.
  always_comb begin
    case (estop_cmd_i)
      STOP_SET:   stop_cmd = STOP_SET;
      STOP_RESET: stop_cmd = STOP_RESET;
      default:    stop_cmd = STOP_NONE;
    endcase
  end

  // Mode transitions and the decision for the current item.
  always_comb begin
    mode_d                 = mode_q;
    cruise_wait_d          = cruise_wait_q;
    planner_wait_d         = planner_wait_q;
    decision_o.src         = SEL_JOY;
    decision_o.cruise_req  = REQ_NONE;
    decision_o.planner_req = REQ_NONE;
    decision_o.base_stop   = stop_cmd;

    if (stop_cmd == STOP_SET) begin
      // A stop only takes effect from an automatic mode.
      if (mode_q == MODE_PLANNER || mode_q == MODE_CRUISE) begin
        mode_d = MODE_STOP;
      end
    end else if (source_select_i == SEL_JOY) begin
      // Joystick selection returns to manual from anywhere.
      if (mode_q == MODE_STOP) begin
        decision_o.base_stop = STOP_RESET;
      end
      mode_d                 = MODE_JOY;
      decision_o.cruise_req  = REQ_DISENGAGE;
      decision_o.planner_req = REQ_DISENGAGE;
    end else begin
      case (mode_q)
        MODE_JOY: begin
          if (source_select_i == SEL_CRUISE) begin
            mode_d                = MODE_TO_CRUISE;
            decision_o.cruise_req = REQ_ENGAGE;
          end else if (source_select_i == SEL_PLANNER) begin
            mode_d                 = MODE_TO_PLANNER;
            decision_o.planner_req = REQ_ENGAGE;
          end
        end
        MODE_TO_CRUISE: begin
          case (cruise_status_i)
            CS_ENGAGED_G, CS_ENGAGED_U: begin
              mode_d        = MODE_CRUISE;
              cruise_wait_d = '0;
            end
            CS_FAILURE: begin
              mode_d                = MODE_JOY;
              cruise_wait_d         = '0;
              decision_o.cruise_req = REQ_DISENGAGE;
            end
            CS_OFF: begin
              mode_d        = MODE_JOY;
              cruise_wait_d = '0;
            end
            default: begin
              // Still trying: count the tick or give up at the limit.
              if (cruise_wait_q >= cruise_lim) begin
                mode_d                = MODE_JOY;
                cruise_wait_d         = '0;
                decision_o.cruise_req = REQ_DISENGAGE;
              end else begin
                cruise_wait_d         = cruise_wait_q + 1'b1;
                decision_o.cruise_req = REQ_ENGAGE;
              end
            end
          endcase
        end
        MODE_CRUISE: begin
          decision_o.src = SEL_CRUISE;
        end
        MODE_TO_PLANNER: begin
          case (planner_status_i)
            PS_ENGAGED: begin
              mode_d         = MODE_PLANNER;
              planner_wait_d = '0;
            end
            PS_FAILURE: begin
              mode_d                 = MODE_JOY;
              planner_wait_d         = '0;
              decision_o.planner_req = REQ_DISENGAGE;
            end
            PS_OFF: begin
              mode_d         = MODE_JOY;
              planner_wait_d = '0;
            end
            default: begin
              if (planner_wait_q >= planner_lim) begin
                mode_d                 = MODE_JOY;
                planner_wait_d         = '0;
                decision_o.planner_req = REQ_DISENGAGE;
              end else begin
                planner_wait_d         = planner_wait_q + 1'b1;
                decision_o.planner_req = REQ_ENGAGE;
              end
            end
          endcase
        end
        MODE_PLANNER: begin
          decision_o.src = SEL_PLANNER;
        end
        default: begin
          // Stopped mode holds until the joystick is selected.
        end
      endcase
    end

    decision_o.mode = mode_d;
  end

  // State advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_JOY;
      cruise_wait_q  <= '0;
      planner_wait_q <= '0;
    end else if (advance_i) begin
      mode_q         <= mode_d;
      cruise_wait_q  <= cruise_wait_d;
      planner_wait_q <= planner_wait_d;
    end
  end

endmodule

@@ rtl/drive_mode_supervisor_top.sv @@
// ----------------------------------------------------------------------------
// Drive mode supervisor
// Chooses, once per control tick, whether the joystick, the cruise controller
// or the path planner drives the mobile base, and issues engage, disengage
// and emergency stop codes.
// ----------------------------------------------------------------------------
// Throughput is one item per clock cycle while the output side is not stalling.
// An accepted item's result appears on the output in the next cycle, from a
// single output register fed by the mode machine's decision logic. The input
// is stalled only while that register holds a result that the output side is
// stalling. The two wait limits reset to 10 and are written through the
// configuration port, which is always ready; writes to indexes beyond the two registers are ignored.
// ----------------------------------------------------------------------------
module drive_mode_supervisor_top import dms_pkg::*; #(
  parameter int unsigned VELOCITY_BITS = 16,
  parameter int unsigned WAIT_BITS     = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [CfgIdxW-1:0]              cfg_index_i,
  input  logic [CfgDataW-1:0]             cfg_data_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      estop_cmd_i,
  input  logic [1:0]                      source_select_i,
  input  logic [2:0]                      cruise_status_i,
  input  logic [2:0]                      planner_status_i,
  input  logic signed [VELOCITY_BITS-1:0] joy_angular_i,
  input  logic signed [VELOCITY_BITS-1:0] joy_linear_i,
  input  logic signed [VELOCITY_BITS-1:0] cruise_angular_i,
  input  logic signed [VELOCITY_BITS-1:0] cruise_linear_i,
  input  logic signed [VELOCITY_BITS-1:0] planner_angular_i,
  input  logic signed [VELOCITY_BITS-1:0] planner_linear_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [VELOCITY_BITS-1:0] drive_angular_o,
  output logic signed [VELOCITY_BITS-1:0] drive_linear_o,
  output logic [1:0]                      cruise_request_o,
  output logic [1:0]                      planner_request_o,
  output logic [1:0]                      base_stop_o,
  output logic [ModeW-1:0]                mode_now_o
);

  localparam logic [CfgDataW-1:0] LimitReset = 8'd10;

  logic                            in_accept;
  logic                            cfg_write;
  logic [CfgDataW-1:0]             cruise_limit_q;
  logic [CfgDataW-1:0]             planner_limit_q;
  dms_decision_t                   decision;
  logic signed [VELOCITY_BITS-1:0] angular_d, linear_d;
  logic                            out_valid_q, out_valid_d;
  logic signed [VELOCITY_BITS-1:0] drive_angular_q, drive_linear_q;
  req_e                            cruise_request_q, planner_request_q;
  stop_e                           base_stop_q;
  logic [ModeW-1:0]                mode_now_q;

  // Handshakes: the input waits only when a held result is being stalled.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_limit_q  <= LimitReset;
      planner_limit_q <= LimitReset;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_CRUISE_LIMIT:  cruise_limit_q  <= cfg_data_i;
        CFG_PLANNER_LIMIT: planner_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dms_mode_fsm #(
    .WAIT_BITS(WAIT_BITS)
  ) u_mode_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (in_accept),
    .estop_cmd_i      (estop_cmd_i),
    .source_select_i  (source_select_i),
    .cruise_status_i  (cruise_status_i),
    .planner_status_i (planner_status_i),
    .cruise_limit_i   (cruise_limit_q),
    .planner_limit_i  (planner_limit_q),
    .decision_o       (decision)
  );

  // Velocity source selection.
  always_comb begin
    case (decision.src)
      SEL_CRUISE: begin
        angular_d = cruise_angular_i;
        linear_d  = cruise_linear_i;
      end
      SEL_PLANNER: begin
        angular_d = planner_angular_i;
        linear_d  = planner_linear_i;
      end
      default: begin
        angular_d = joy_angular_i;
        linear_d  = joy_linear_i;
      end
    endcase
  end

  // Output register: valid holds while stalled, loads on every accepted item.
  assign out_valid_d = in_accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      drive_angular_q   <= angular_d;
      drive_linear_q    <= linear_d;
      cruise_request_q  <= decision.cruise_req;
      planner_request_q <= decision.planner_req;
      base_stop_q       <= decision.base_stop;
      mode_now_q        <= decision.mode;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_angular_o   = drive_angular_q;
  assign drive_linear_o    = drive_linear_q;
  assign cruise_request_o  = cruise_request_q;
  assign planner_request_o = planner_request_q;
  assign base_stop_o       = base_stop_q;
  assign mode_now_o        = mode_now_q;

endmodule

@@ rtl/dms_checker.sv @@
// ----------------------------------------------------------------------------
// Drive mode supervisor checker
// Watches the top level's ports and checks flow control and the result of
// stop commands and joystick selection.
// ----------------------------------------------------------------------------
`include "drive_mode_supervisor_top_macros.svh"

module dms_checker import dms_pkg::*; #(
  parameter int unsigned VELOCITY_BITS = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [1:0]                      estop_cmd_i,
  input logic [1:0]                      source_select_i,
  input logic signed [VELOCITY_BITS-1:0] joy_angular_i,
  input logic signed [VELOCITY_BITS-1:0] joy_linear_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [VELOCITY_BITS-1:0] drive_angular_o,
  input logic signed [VELOCITY_BITS-1:0] drive_linear_o,
  input logic [1:0]                      cruise_request_o,
  input logic [1:0]                      planner_request_o,
  input logic [1:0]                      base_stop_o
);

  logic                            in_acc;
  logic                            stop_pick;
  logic                            joy_pick;
  logic                            joy_out_ok;
  logic signed [VELOCITY_BITS-1:0] joy_ang_q, joy_lin_q;

  assign in_acc    = in_valid_i & ~in_stall_o;
  assign stop_pick = in_acc && estop_cmd_i == STOP_SET;
  assign joy_pick  = in_acc && estop_cmd_i != STOP_SET && source_select_i == SEL_JOY;

  // Joystick velocities offered in the previous cycle.
  always_ff @(posedge clk_i) begin
    joy_ang_q <= joy_angular_i;
    joy_lin_q <= joy_linear_i;
  end

  // The result of a joystick selection.
  assign joy_out_ok = out_valid_o && drive_angular_o == joy_ang_q &&
                      drive_linear_o == joy_lin_q &&
                      cruise_request_o == REQ_DISENGAGE &&
                      planner_request_o == REQ_DISENGAGE;

  // A stalled result stays presented.
  `DMS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // No item may enter while a held result is being stalled.
  `DMS_ASSERT_SAME(a_in_blocked, out_valid_o && out_stall_i, in_stall_o)

  // A stop command is always echoed to the base in the next result.
  `DMS_ASSERT_NEXT(a_stop_echo, stop_pick, out_valid_o && base_stop_o == STOP_SET)

  // Joystick selection drives joystick velocities and disengages both units.
  `DMS_ASSERT_NEXT(a_joy_return, joy_pick, joy_out_ok)

endmodule

bind drive_mode_supervisor_top dms_checker #(
  .VELOCITY_BITS(VELOCITY_BITS)
) u_dms_checker (.*);

@@ sim/tb_drive_mode_supervisor_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drive mode supervisor testbench
// Drives control ticks into the supervisor with random gaps on the input and
// random stalls on the output. A scoreboard predicts each tick's drive
// command from its own copy of the mode machine. Every result is checked
// field by field, in order. The wait limits are changed between phases.
// ----------------------------------------------------------------------------
module tb_drive_mode_supervisor_top;
  import dms_pkg::*;

  localparam int unsigned VelW  = 16;
  localparam int unsigned WaitW = 8;

  // Codes that the package does not name but that the ports can carry.
  localparam logic [1:0] STOP_CODE3 = 2'd3;
  localparam logic [1:0] SEL_CODE3  = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDX2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX3 = 2'd3;

  // Cruise controller status codes.
  localparam logic [2:0] CST_OFF       = 3'd0;
  localparam logic [2:0] CST_ON        = 3'd1;
  localparam logic [2:0] CST_TRYING    = 3'd2;
  localparam logic [2:0] CST_ENGAGED_G = 3'd3;
  localparam logic [2:0] CST_ENGAGED_U = 3'd4;
  localparam logic [2:0] CST_FAILURE   = 3'd5;
  localparam logic [2:0] CST_CODE6     = 3'd6;
  localparam logic [2:0] CST_CODE7     = 3'd7;

  // Path planner status codes.
  localparam logic [2:0] PST_OFF       = 3'd0;
  localparam logic [2:0] PST_ON        = 3'd1;
  localparam logic [2:0] PST_TRYING    = 3'd2;
  localparam logic [2:0] PST_ENGAGED   = 3'd3;
  localparam logic [2:0] PST_FAILURE   = 3'd4;
  localparam logic [2:0] PST_GOAL_OK   = 3'd5;
  localparam logic [2:0] PST_GOAL_FAIL = 3'd6;
  localparam logic [2:0] PST_CODE7     = 3'd7;

  typedef enum logic [ModeW-1:0] {
    MODE_JOY        = 3'd0,
    MODE_TO_CRUISE  = 3'd1,
    MODE_CRUISE     = 3'd2,
    MODE_TO_PLANNER = 3'd3,
    MODE_PLANNER    = 3'd4,
    MODE_STOP       = 3'd5
  } mode_e;

  // One control tick as offered on the input channel.
  typedef struct packed {
    logic [1:0]            estop;
    logic [1:0]            sel;
    logic [2:0]            cst;
    logic [2:0]            pst;
    logic signed [VelW-1:0] joy_ang;
    logic signed [VelW-1:0] joy_lin;
    logic signed [VelW-1:0] cr_ang;
    logic signed [VelW-1:0] cr_lin;
    logic signed [VelW-1:0] pl_ang;
    logic signed [VelW-1:0] pl_lin;
  } tick_t;

  // One drive command as seen on the output channel.
  typedef struct packed {
    logic signed [VelW-1:0] angular;
    logic signed [VelW-1:0] linear;
    logic [1:0]             cruise_req;
    logic [1:0]             planner_req;
    logic [1:0]             base_stop;
    logic [ModeW-1:0]       mode;
  } drive_t;

  // Mode machine model and the queue of drive commands still to arrive.
  class mode_scoreboard;
    mode_e            mode;
    logic [WaitW-1:0] cruise_wait;
    logic [WaitW-1:0] planner_wait;
    logic [7:0]       cruise_limit;
    logic [7:0]       planner_limit;
    drive_t           expected_drives[$];
    int               errors;
    int               n_checked;
    int               n_giveups;
    int               mode_hits[6];

    function new();
      mode          = MODE_JOY;
      cruise_wait   = '0;
      planner_wait  = '0;
      cruise_limit  = 8'd10;
      planner_limit = 8'd10;
      errors        = 0;
      n_checked     = 0;
      n_giveups     = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_CRUISE_LIMIT) cruise_limit = data;
      else if (idx == CFG_PLANNER_LIMIT) planner_limit = data;
    endfunction

    // Advances the model by one tick and returns the drive command it yields.
    function drive_t next_drive(tick_t t);
      drive_t     r;
      logic [1:0] stop_code;
      stop_code     = (t.estop == STOP_CODE3) ? STOP_NONE : t.estop;
      r.angular     = t.joy_ang;
      r.linear      = t.joy_lin;
      r.cruise_req  = REQ_NONE;
      r.planner_req = REQ_NONE;
      r.base_stop   = stop_code;
      if (stop_code == STOP_SET) begin
        // A stop is taken only from an automatic mode.
        if (mode == MODE_PLANNER || mode == MODE_CRUISE) mode = MODE_STOP;
      end else if (t.sel == SEL_JOY) begin
        if (mode == MODE_STOP) r.base_stop = STOP_RESET;
        mode          = MODE_JOY;
        r.cruise_req  = REQ_DISENGAGE;
        r.planner_req = REQ_DISENGAGE;
      end else begin
        case (mode)
          MODE_JOY: begin
            if (t.sel == SEL_CRUISE) begin
              mode         = MODE_TO_CRUISE;
              r.cruise_req = REQ_ENGAGE;
            end else if (t.sel == SEL_PLANNER) begin
              mode          = MODE_TO_PLANNER;
              r.planner_req = REQ_ENGAGE;
            end
          end
          MODE_TO_CRUISE: begin
            if (t.cst == CST_ENGAGED_G || t.cst == CST_ENGAGED_U) begin
              mode        = MODE_CRUISE;
              cruise_wait = '0;
            end else if (t.cst == CST_FAILURE) begin
              mode         = MODE_JOY;
              cruise_wait  = '0;
              r.cruise_req = REQ_DISENGAGE;
            end else if (t.cst == CST_OFF) begin
              mode        = MODE_JOY;
              cruise_wait = '0;
            end else if (cruise_wait >= cruise_limit) begin
              mode         = MODE_JOY;
              cruise_wait  = '0;
              r.cruise_req = REQ_DISENGAGE;
              n_giveups++;
            end else begin
              cruise_wait  = cruise_wait + 1'b1;
              r.cruise_req = REQ_ENGAGE;
            end
          end
          MODE_CRUISE: begin
            r.angular = t.cr_ang;
            r.linear  = t.cr_lin;
          end
          MODE_TO_PLANNER: begin
            if (t.pst == PST_ENGAGED) begin
              mode         = MODE_PLANNER;
              planner_wait = '0;
            end else if (t.pst == PST_FAILURE) begin
              mode          = MODE_JOY;
              planner_wait  = '0;
              r.planner_req = REQ_DISENGAGE;
            end else if (t.pst == PST_OFF) begin
              mode         = MODE_JOY;
              planner_wait = '0;
            end else if (planner_wait >= planner_limit) begin
              mode          = MODE_JOY;
              planner_wait  = '0;
              r.planner_req = REQ_DISENGAGE;
              n_giveups++;
            end else begin
              planner_wait  = planner_wait + 1'b1;
              r.planner_req = REQ_ENGAGE;
            end
          end
          MODE_PLANNER: begin
            r.angular = t.pl_ang;
            r.linear  = t.pl_lin;
          end
          default: ;
        endcase
      end
      r.mode = mode;
      mode_hits[mode]++;
      return r;
    endfunction

    function void note_tick(tick_t t);
      expected_drives.push_back(next_drive(t));
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      n_checked++;
      if (expected_drives.size() == 0) begin
        $error("drive command with no tick outstanding: mode_now %0d", got.mode);
        errors++;
        return;
      end
      want = expected_drives.pop_front();
      if (got.angular !== want.angular) begin
        $error("drive_angular: expected %0d, actual %0d", want.angular, got.angular);
        errors++;
      end
      if (got.linear !== want.linear) begin
        $error("drive_linear: expected %0d, actual %0d", want.linear, got.linear);
        errors++;
      end
      if (got.cruise_req !== want.cruise_req) begin
        $error("cruise_request: expected %0d, actual %0d", want.cruise_req, got.cruise_req);
        errors++;
      end
      if (got.planner_req !== want.planner_req) begin
        $error("planner_request: expected %0d, actual %0d", want.planner_req,
               got.planner_req);
        errors++;
      end
      if (got.base_stop !== want.base_stop) begin
        $error("base_stop: expected %0d, actual %0d", want.base_stop, got.base_stop);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("mode_now: expected %0d, actual %0d", want.mode, got.mode);
        errors++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  // Clock, reset and block ports.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic  in_valid = 1'b0;
  logic  in_stall;
  tick_t tick_q   = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b1;
  logic signed [VelW-1:0] drive_angular;
  logic signed [VelW-1:0] drive_linear;
  logic [1:0]             cruise_request;
  logic [1:0]             planner_request;
  logic [1:0]             base_stop;
  logic [ModeW-1:0]       mode_now;

  mode_scoreboard sb = new();

  int n_ticks     = 0;
  int n_cfg       = 0;
  int rx_hold_req = 0;
  bit no_gaps     = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  drive_mode_supervisor_top #(
    .VELOCITY_BITS(VelW),
    .WAIT_BITS    (WaitW)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .estop_cmd_i      (tick_q.estop),
    .source_select_i  (tick_q.sel),
    .cruise_status_i  (tick_q.cst),
    .planner_status_i (tick_q.pst),
    .joy_angular_i    (tick_q.joy_ang),
    .joy_linear_i     (tick_q.joy_lin),
    .cruise_angular_i (tick_q.cr_ang),
    .cruise_linear_i  (tick_q.cr_lin),
    .planner_angular_i(tick_q.pl_ang),
    .planner_linear_i (tick_q.pl_lin),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .drive_angular_o  (drive_angular),
    .drive_linear_o   (drive_linear),
    .cruise_request_o (cruise_request),
    .planner_request_o(planner_request),
    .base_stop_o      (base_stop),
    .mode_now_o       (mode_now)
  );

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Output side: draws a stall per item, or takes a long hold when asked.
  initial begin : drive_receiver
    int     hold;
    drive_t got;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      got.angular     = drive_angular;
      got.linear      = drive_linear;
      got.cruise_req  = cruise_request;
      got.planner_req = planner_request;
      got.base_stop   = base_stop;
      got.mode        = mode_now;
      sb.check_drive(got);
    end
  end

  // Velocity with a bias toward the extremes of the signed range.
  function automatic logic signed [VelW-1:0] rnd_vel();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return VelW'($urandom);
    endcase
  endfunction

  // Any status code, including the unused ones.
  function automatic logic [2:0] any_status();
    return 3'($urandom_range(0, 7));
  endfunction

  // Any two-bit stop or selection code.
  function automatic logic [1:0] any_code();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic tick_t mk(logic [1:0] e, logic [1:0] s, logic [2:0] c, logic [2:0] p);
    tick_t t;
    t.estop   = e;
    t.sel     = s;
    t.cst     = c;
    t.pst     = p;
    t.joy_ang = rnd_vel();
    t.joy_lin = rnd_vel();
    t.cr_ang  = rnd_vel();
    t.cr_lin  = rnd_vel();
    t.pl_ang  = rnd_vel();
    t.pl_lin  = rnd_vel();
    return t;
  endfunction

  // Cruise codes that keep an engage attempt waiting.
  function automatic logic [2:0] cruise_busy();
    case ($urandom_range(0, 3))
      0:       return CST_ON;
      1:       return CST_TRYING;
      2:       return CST_CODE6;
      default: return CST_CODE7;
    endcase
  endfunction

  // Planner codes that keep an engage attempt waiting.
  function automatic logic [2:0] planner_busy();
    case ($urandom_range(0, 4))
      0:       return PST_ON;
      1:       return PST_TRYING;
      2:       return PST_GOAL_OK;
      3:       return PST_GOAL_FAIL;
      default: return PST_CODE7;
    endcase
  endfunction

  // Stop command that does not take the stop path.
  function automatic logic [1:0] quiet_stop();
    case ($urandom_range(0, 3))
      0:       return STOP_RESET;
      1:       return STOP_CODE3;
      default: return STOP_NONE;
    endcase
  endfunction

  // Any selection other than the joystick.
  function automatic logic [1:0] auto_sel();
    case ($urandom_range(0, 2))
      0:       return SEL_CRUISE;
      1:       return SEL_PLANNER;
      default: return SEL_CODE3;
    endcase
  endfunction

  // Offers one item after a random gap and returns once it is accepted.
  task automatic send_tick(tick_t t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    tick_q   <= t;
    do @(posedge clk_i); while (in_stall);
    sb.note_tick(t);
    n_ticks++;
  endtask

  // Stops offering items and waits until every result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, data);
    n_cfg++;
  endtask

  // Writes both limits, sometimes with a stray write to an unused index.
  task automatic set_limits(logic [7:0] cruise_lim, logic [7:0] planner_lim);
    cfg_write(CFG_CRUISE_LIMIT, cruise_lim);
    if ($urandom_range(0, 1)) cfg_write($urandom_range(0, 1) ? CFG_IDX2 : CFG_IDX3,
                                        CfgDataW'($urandom));
    cfg_write(CFG_PLANNER_LIMIT, planner_lim);
    cfg_valid <= 1'b0;
  endtask

  // Holds an engage attempt with waiting status codes until the mode gives up.
  task automatic wait_out(logic [1:0] src);
    int n;
    n = 0;
    send_tick(mk(STOP_NONE, SEL_JOY, CST_OFF, PST_OFF));
    send_tick(mk(STOP_NONE, src, CST_OFF, PST_OFF));
    while ((sb.mode == MODE_TO_CRUISE || sb.mode == MODE_TO_PLANNER) && n < 300) begin
      send_tick(mk(quiet_stop(), src, cruise_busy(), planner_busy()));
      n++;
    end
  endtask

  // One engage attempt with random content, ended in one of several ways.
  task automatic engage_session();
    logic [1:0] src;
    int         lim;
    int         tries;
    int         stay;
    bit         to_cruise;
    to_cruise = 1'($urandom_range(0, 1));
    src       = to_cruise ? SEL_CRUISE : SEL_PLANNER;
    lim       = to_cruise ? int'(sb.cruise_limit) : int'(sb.planner_limit);
    if (lim > 8) lim = 8;
    send_tick(mk(quiet_stop(), SEL_JOY, any_status(), any_status()));
    send_tick(mk(quiet_stop(), src, any_status(), any_status()));
    tries = $urandom_range(0, lim + 2);
    repeat (tries) begin
      send_tick(mk(($urandom_range(0, 7) == 0) ? STOP_SET : quiet_stop(), auto_sel(),
                   cruise_busy(), planner_busy()));
    end
    case ($urandom_range(0, 9))
      6: send_tick(mk(quiet_stop(), auto_sel(), CST_FAILURE, PST_FAILURE));
      7: send_tick(mk(quiet_stop(), auto_sel(), CST_OFF, PST_OFF));
      8: send_tick(mk(quiet_stop(), SEL_JOY, cruise_busy(), planner_busy()));
      9: ;
      default: begin
        send_tick(mk(quiet_stop(), auto_sel(),
                     $urandom_range(0, 1) ? CST_ENGAGED_G : CST_ENGAGED_U, PST_ENGAGED));
        stay = $urandom_range(0, 5);
        repeat (stay) begin
          send_tick(mk(quiet_stop(), auto_sel(), any_status(), any_status()));
        end
        if ($urandom_range(0, 1)) begin
          send_tick(mk(STOP_SET, any_code(), any_status(), any_status()));
          stay = $urandom_range(0, 3);
          repeat (stay) begin
            send_tick(mk(any_code(), auto_sel(), any_status(), any_status()));
          end
        end
        send_tick(mk(quiet_stop(), SEL_JOY, any_status(), any_status()));
      end
    endcase
  endtask

  // Stimulus: directed ticks, then phases of random sessions per limit setting.
  initial begin : tick_sender
    int ph;
    int start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Manual mode, stray stop codes and the unused selection.
    send_tick(mk(STOP_NONE, SEL_JOY, CST_OFF, PST_OFF));
    send_tick(mk(STOP_SET, SEL_CRUISE, CST_ENGAGED_G, PST_ENGAGED));
    send_tick(mk(STOP_CODE3, SEL_JOY, CST_CODE7, PST_CODE7));
    send_tick(mk(STOP_NONE, SEL_CODE3, CST_ENGAGED_U, PST_ENGAGED));
    // Cruise engage with waiting codes, then stop and return to manual.
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_OFF, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_TRYING, PST_OFF));
    send_tick(mk(STOP_RESET, SEL_PLANNER, CST_CODE6, PST_ENGAGED));
    send_tick(mk(STOP_NONE, SEL_CODE3, CST_ENGAGED_G, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_PLANNER, CST_FAILURE, PST_FAILURE));
    send_tick(mk(STOP_SET, SEL_CRUISE, CST_ON, PST_ON));
    send_tick(mk(STOP_RESET, SEL_PLANNER, CST_ENGAGED_G, PST_ENGAGED));
    send_tick(mk(STOP_NONE, SEL_JOY, CST_OFF, PST_OFF));
    // Planner engage with goal codes, then stop and return to manual.
    send_tick(mk(STOP_NONE, SEL_PLANNER, CST_OFF, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_PLANNER, CST_OFF, PST_GOAL_OK));
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_ENGAGED_G, PST_GOAL_FAIL));
    send_tick(mk(STOP_NONE, SEL_PLANNER, CST_OFF, PST_ENGAGED));
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_OFF, PST_OFF));
    send_tick(mk(STOP_SET, SEL_JOY, CST_OFF, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_JOY, CST_OFF, PST_OFF));
    // Failure and off while engaging.
    send_tick(mk(STOP_NONE, SEL_PLANNER, CST_OFF, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_PLANNER, CST_OFF, PST_FAILURE));
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_OFF, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_FAILURE, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_OFF, PST_OFF));
    send_tick(mk(STOP_NONE, SEL_CRUISE, CST_OFF, PST_ENGAGED));

    for (ph = 0; ph < 9; ph++) begin
      drain();
      case (ph)
        0:       set_limits(8'd0, 8'd0);
        1:       set_limits(8'd255, 8'd255);
        2:       set_limits(8'd1, 8'd3);
        3:       set_limits(8'd10, 8'd0);
        default: set_limits(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
      endcase
      if (ph == 1) begin
        wait_out(SEL_CRUISE);
        wait_out(SEL_PLANNER);
      end
      if (ph == 4) rx_hold_req = 60;
      start = n_ticks;
      while (n_ticks - start < 60) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
          send_tick(mk(any_code(), any_code(), any_status(), any_status()));
        end else begin
          engage_session();
        end
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("summary: %0d ticks, %0d results checked, %0d limit writes, %0d give-ups",
             n_ticks, sb.n_checked, n_cfg, sb.n_giveups);
    $display("summary: results per mode joy %0d, to-cruise %0d, cruise %0d, to-planner %0d,",
             sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3]);
    $display("summary: planner %0d, stopped %0d", sb.mode_hits[4], sb.mode_hits[5]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dms_pkg.sv
rtl/dms_mode_fsm.sv
rtl/drive_mode_supervisor_top.sv
rtl/dms_checker.sv
sim/tb_drive_mode_supervisor_top.sv
